// ===== src/sha1_message_digest_assert.svh =====
// Assertion macros for the SHA-1 digest port checker.
`ifndef SHA1_MESSAGE_DIGEST_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define SHA1_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define SHA1_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/sha1md_pkg.sv =====
// Package: types, constants and round functions of the SHA-1 digest block.
package sha1md_pkg;

	localparam int unsigned NUM_WORDS = 5;
	localparam logic [2:0] LAST_IDX = 3'd4;
	localparam logic [6:0] ROUNDS = 7'd80;
	localparam logic [6:0] SCHED_WORDS = 7'd16;
	localparam logic [5:0] LEN_POS = 6'd56;
	localparam logic [5:0] LAST_POS = 6'd63;
	localparam logic [7:0] PAD_MARK = 8'h80;

	localparam logic [31:0] H_INIT [NUM_WORDS] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
	};

	localparam logic [31:0] K_0 = 32'h5a827999;
	localparam logic [31:0] K_1 = 32'h6ed9eba1;
	localparam logic [31:0] K_2 = 32'h8f1bbcdc;
	localparam logic [31:0] K_3 = 32'hca62c1d6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LOAD,
		ST_COMP,
		ST_EMIT
	} state_t;

	// Control from the sequencer to the round datapath
	typedef struct packed {
		logic       load;   // copy chaining words into working words
		logic       round;  // run one round
		logic       add;    // fold working words into chaining words
		logic       init;   // return chaining words to initial values
		logic [6:0] rnd;    // round number
	} core_ctl_t;

	function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
		return (v << n) | (v >> (32 - n));
	endfunction

endpackage

// ===== src/sha1md_buf.sv =====
// Block buffer: 16 x 32-bit memory, byte writes, registered word read.
module sha1md_buf (
	input  logic        clk,
	input  logic        we,
	input  logic [3:0]  waddr,
	input  logic [1:0]  lane,
	input  logic [7:0]  wbyte,
	input  logic [3:0]  raddr,
	output logic [31:0] rdata
);
	logic [31:0] mem_q [16];
	logic [31:0] rdata_q;

	// byte write into one lane of a word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr][8*lane +: 8] <= wbyte;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

// ===== src/sha1md_core.sv =====
// Round datapath: chaining words, working words and the schedule window.
module sha1md_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  sha1md_pkg::core_ctl_t ctl,
	input  logic [31:0]           rdata,
	input  logic [2:0]            word_sel,
	output logic [31:0]           digest_word
);
	import sha1md_pkg::*;

	logic [31:0] h_q [NUM_WORDS];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] win_q [16];
	logic [31:0] w_t, f_t, k_t, t_t;

	// schedule word: first 16 from the buffer, then from the window
	always_comb begin
		if (ctl.rnd < SCHED_WORDS) begin
			w_t = rdata;
		end else begin
			w_t = rotl(win_q[13] ^ win_q[8] ^ win_q[2] ^ win_q[0], 1);
		end
	end

	// round function and constant by phase
	always_comb begin
		if (ctl.rnd < 7'd20) begin
			f_t = (b_q & c_q) | (~b_q & d_q);
			k_t = K_0;
		end else if (ctl.rnd < 7'd40) begin
			f_t = b_q ^ c_q ^ d_q;
			k_t = K_1;
		end else if (ctl.rnd < 7'd60) begin
			f_t = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			k_t = K_2;
		end else begin
			f_t = b_q ^ c_q ^ d_q;
			k_t = K_3;
		end
		t_t = rotl(a_q, 5) + f_t + e_q + k_t + w_t;
	end

	// working words and window
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			a_q <= h_q[0];
			b_q <= h_q[1];
			c_q <= h_q[2];
			d_q <= h_q[3];
			e_q <= h_q[4];
		end else if (ctl.round) begin
			a_q <= t_t;
			b_q <= a_q;
			c_q <= rotl(b_q, 30);
			d_q <= c_q;
			e_q <= d_q;
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[15] <= w_t;
		end
	end

	// chaining words
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WORDS; i++) begin
				h_q[i] <= H_INIT[i];
			end
		end else if (ctl.init) begin
			for (int i = 0; i < NUM_WORDS; i++) begin
				h_q[i] <= H_INIT[i];
			end
		end else if (ctl.add) begin
			h_q[0] <= h_q[0] + a_q;
			h_q[1] <= h_q[1] + b_q;
			h_q[2] <= h_q[2] + c_q;
			h_q[3] <= h_q[3] + d_q;
			h_q[4] <= h_q[4] + e_q;
		end
	end

	// digest word select
	always_comb begin
		case (word_sel)
			3'd0: digest_word = h_q[0];
			3'd1: digest_word = h_q[1];
			3'd2: digest_word = h_q[2];
			3'd3: digest_word = h_q[3];
			3'd4: digest_word = h_q[4];
			default: digest_word = '0;
		endcase
	end
endmodule

// ===== src/sha1_message_digest.sv =====
// SHA-1 digest engine: byte intake, padding sequencer, block buffer and rounds.
// Bytes: one item per cycle while idle; none taken during compress, pad or emit.
// A full block runs load, 80 rounds at one per cycle, then add.
// End of message: padding over one or two blocks, then 5 word items.
// Reset (async, arst_n low) clears control, sets initial chaining words and a
// zero bit count; the block buffer is not cleared.
module sha1_message_digest (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] byte_present
	input  logic        s_tlast,   // end_of_message
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] digest_word
	output logic [2:0]  m_tuser,   // [2:0] word_index
	output logic        m_tlast    // last_word
);
	import sha1md_pkg::*;

	state_t      state_q, state_d;
	logic [60:0] byte_cnt_q, byte_cnt_d;
	logic [5:0]  pad_pos_q, pad_pos_d;
	logic        pad_first_q, pad_first_d;
	logic        len_ok_q, len_ok_d;
	logic        pad_go_q, pad_go_d;
	logic        final_q, final_d;
	logic [6:0]  rnd_q, rnd_d;
	logic [2:0]  emit_idx_q, emit_idx_d;

	logic        in_acc, out_acc;
	logic [5:0]  fill, fill_new;
	logic [63:0] bit_len;
	logic [7:0]  len_byte;
	logic        we;
	logic [5:0]  wpos;
	logic [7:0]  wbyte;
	logic [3:0]  raddr;
	logic [31:0] rdata;
	core_ctl_t   ctl;

	assign in_acc   = s_tvalid && s_tready;
	assign out_acc  = m_tvalid && m_tready;
	assign fill     = byte_cnt_q[5:0];
	assign fill_new = fill + {5'd0, s_tuser};
	assign bit_len  = {byte_cnt_q, 3'b000};
	assign len_byte = bit_len[8*(7 - int'(pad_pos_q[2:0])) +: 8];

	// sequencer
	always_comb begin
		state_d     = state_q;
		byte_cnt_d  = byte_cnt_q;
		pad_pos_d   = pad_pos_q;
		pad_first_d = pad_first_q;
		len_ok_d    = len_ok_q;
		pad_go_d    = pad_go_q;
		final_d     = final_q;
		rnd_d       = rnd_q;
		emit_idx_d  = emit_idx_q;
		we          = 1'b0;
		wpos        = fill;
		wbyte       = s_tdata;
		ctl         = '0;
		ctl.rnd     = rnd_q;
		s_tready    = 1'b0;
		m_tvalid    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (in_acc) begin
					if (s_tuser) begin
						we         = 1'b1;
						byte_cnt_d = byte_cnt_q + 61'd1;
					end
					if (s_tlast) begin
						pad_go_d    = 1'b1;
						pad_pos_d   = fill_new;
						pad_first_d = 1'b1;
						len_ok_d    = fill_new < LEN_POS;
					end
					if (s_tuser && fill == LAST_POS) begin
						final_d = 1'b0;
						state_d = ST_LOAD;
					end else if (s_tlast) begin
						state_d = ST_PAD;
					end
				end
			end
			ST_PAD: begin
				// mark, zeros, then the length bytes when they fit
				we    = 1'b1;
				wpos  = pad_pos_q;
				if (pad_first_q) begin
					wbyte = PAD_MARK;
				end else if (len_ok_q && pad_pos_q >= LEN_POS) begin
					wbyte = len_byte;
				end else begin
					wbyte = 8'd0;
				end
				pad_first_d = 1'b0;
				pad_pos_d   = pad_pos_q + 6'd1;
				if (pad_pos_q == LAST_POS) begin
					final_d  = len_ok_q;
					len_ok_d = 1'b1;
					state_d  = ST_LOAD;
				end
			end
			ST_LOAD: begin
				ctl.load = 1'b1;
				rnd_d    = 7'd0;
				state_d  = ST_COMP;
			end
			ST_COMP: begin
				if (rnd_q < ROUNDS) begin
					ctl.round = 1'b1;
					rnd_d     = rnd_q + 7'd1;
				end else begin
					ctl.add = 1'b1;
					if (final_q) begin
						emit_idx_d = 3'd0;
						state_d    = ST_EMIT;
					end else if (pad_go_q) begin
						state_d = ST_PAD;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_EMIT: begin
				m_tvalid = 1'b1;
				if (out_acc) begin
					emit_idx_d = emit_idx_q + 3'd1;
					if (emit_idx_q == LAST_IDX) begin
						ctl.init   = 1'b1;
						byte_cnt_d = '0;
						pad_go_d   = 1'b0;
						final_d    = 1'b0;
						state_d    = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			byte_cnt_q  <= '0;
			pad_pos_q   <= '0;
			pad_first_q <= 1'b0;
			len_ok_q    <= 1'b0;
			pad_go_q    <= 1'b0;
			final_q     <= 1'b0;
			rnd_q       <= '0;
			emit_idx_q  <= '0;
		end else begin
			state_q     <= state_d;
			byte_cnt_q  <= byte_cnt_d;
			pad_pos_q   <= pad_pos_d;
			pad_first_q <= pad_first_d;
			len_ok_q    <= len_ok_d;
			pad_go_q    <= pad_go_d;
			final_q     <= final_d;
			rnd_q       <= rnd_d;
			emit_idx_q  <= emit_idx_d;
		end
	end

	// next schedule word read ahead of the round that uses it
	assign raddr = (state_q == ST_LOAD) ? 4'd0 : (rnd_q[3:0] + 4'd1);

	sha1md_buf u_buf (
		.clk   (clk),
		.we    (we),
		.waddr (wpos[5:2]),
		.lane  (~wpos[1:0]),
		.wbyte (wbyte),
		.raddr (raddr),
		.rdata (rdata)
	);

	sha1md_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.rdata       (rdata),
		.word_sel    (emit_idx_q),
		.digest_word (m_tdata)
	);

	assign m_tuser = emit_idx_q;
	assign m_tlast = (emit_idx_q == LAST_IDX);
endmodule

// ===== src/sha1md_chk.sv =====
// Port checker for the SHA-1 digest block, bound to the top level.
`include "sha1_message_digest_assert.svh"

module sha1md_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [2:0]  m_tuser,
	input logic        m_tlast
);
	// word index stays within the digest
	`SHA1_ASSERT_NOW(a_idx_range, m_tvalid, m_tuser <= 3'd4, "word index out of range")
	// last flag only on the fifth word
	`SHA1_ASSERT_NOW(a_last_idx, m_tvalid && m_tlast, m_tuser == 3'd4, "last word not at index 4")
	// no intake while a digest is being delivered
	`SHA1_ASSERT_NOW(a_no_overlap, m_tvalid, !s_tready, "input ready during digest output")
	// digest ends cleanly
	`SHA1_ASSERT_NEXT(a_end_digest, m_tvalid && m_tready && m_tlast, !m_tvalid, "extra word after last")
	// stalled word holds
	`SHA1_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled word changed")
endmodule

bind sha1_message_digest sha1md_chk u_chk (.*);
